// ===== hdl/irt_pkg.sv =====
`default_nettype none

package irt_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int INODE_BITS_DEF = 16;
  localparam int REF_BITS_DEF   = 8;

  // Fixed port field widths
  localparam int REQ_W    = 2;
  localparam int INODE_W  = 16;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int REFS_W   = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_GET   = 2'd0,
    REQ_PUT   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT           = 3'd0,
    ST_LOADED_NEW    = 3'd1,
    ST_FULL          = 3'd2,
    ST_RELEASED      = 3'd3,
    ST_RELEASED_LAST = 3'd4,
    ST_IDLE_PUT      = 3'd5,
    ST_CLEARED       = 3'd6
  } status_t;

  // Update command broadcast to every cell in the execute cycle
  typedef struct packed {
    logic go;
    logic is_get;
    logic is_put;
    logic is_clear;
    logic any_hit;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/irt_cell.sv =====
`default_nettype none

module irt_cell #(
  parameter int INODE_BITS = irt_pkg::INODE_BITS_DEF,
  parameter int REF_BITS   = irt_pkg::REF_BITS_DEF,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cap,
  input  wire logic [INODE_BITS-1:0]     cap_inode,
  input  wire logic [irt_pkg::SLOT_W-1:0] cap_slot,
  input  wire irt_pkg::cmd_t             cmd,
  input  wire logic [INODE_BITS-1:0]     new_inode,
  input  wire logic                      hit_in,
  input  wire logic                      free_in,
  output logic                           hit_out,
  output logic                           free_out,
  output logic                           win_hit,
  output logic                           win_free,
  output logic                           psel,
  output logic [REF_BITS-1:0]            count,
  output logic [INODE_BITS-1:0]          inode
);

  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  logic match;
  logic free;

  // Priority chain: the first matching or free cell from index zero wins
  assign hit_out  = hit_in | match;
  assign free_out = free_in | free;
  assign win_hit  = match & ~hit_in;
  assign win_free = free & ~free_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      match <= 1'b0;
      free  <= 1'b0;
      psel  <= 1'b0;
    end else begin
      if (cap) begin
        match <= (count != '0) && (inode == cap_inode);
        free  <= (count == '0);
        psel  <= (32'(cap_slot) == 32'(CELL_IDX));
      end
      if (cmd.go) begin
        if (cmd.is_clear) begin
          count <= '0;
        end else if (cmd.is_get) begin
          if (cmd.any_hit) begin
            if (win_hit && count != REF_MAX) begin
              count <= count + 1'b1;
            end
          end else if (win_free) begin
            count <= REF_BITS'(1);
          end
        end else if (cmd.is_put && psel && count != '0) begin
          count <= count - 1'b1;
        end
      end
    end
  end

  // Inode store needs no reset: it is read only while the slot is live
  always_ff @(posedge clk) begin
    if (cmd.go && cmd.is_get && !cmd.any_hit && win_free) begin
      inode <= new_inode;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/inode_refcount_table_unit.sv =====
`default_nettype none

// Open-inode slot table with reference counts. Raise start with a request
// while busy is low; the request is taken at that clock edge, busy is high for
// the one execute cycle that follows, and the result appears on the result
// ports with done high for exactly one cycle right after it. A new request may
// be started in the cycle that done shows; none is taken while busy is high.
// The receiver cannot stall and must take each result while done is high. In
// the accept cycle every slot cell compares its inode number with the request
// in parallel; in the execute cycle of a get a priority chain running through
// the cells from slot zero picks the hit or the lowest free slot, and the
// chosen cell updates its count. A request of the unknown type still takes the
// execute cycle but gives no result. Counts clear on reset with no clearing
// pass; a slot's inode number is defined once a get claims it.
module inode_refcount_table_unit #(
  parameter int SLOT_COUNT = irt_pkg::SLOT_COUNT_DEF,
  parameter int INODE_BITS = irt_pkg::INODE_BITS_DEF,
  parameter int REF_BITS   = irt_pkg::REF_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [irt_pkg::REQ_W-1:0]     req_type,
  input  wire logic [irt_pkg::INODE_W-1:0]   inode_number,
  input  wire logic [irt_pkg::SLOT_W-1:0]    slot_index,
  output logic                               busy,
  output logic                               done,
  output logic [irt_pkg::STATUS_W-1:0]       status,
  output logic [irt_pkg::SLOT_W-1:0]         slot_out,
  output logic [irt_pkg::REFS_W-1:0]         refs_after,
  output logic [irt_pkg::INODE_W-1:0]        inode_out,
  output logic                               count_saturated
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  irt_pkg::req_t                req;
  logic [INODE_BITS-1:0]        req_inode;
  logic [irt_pkg::SLOT_W-1:0]   req_slot;

  logic                         cap;
  irt_pkg::cmd_t                cmd;

  logic [SLOT_COUNT:0]          hit_chain;
  logic [SLOT_COUNT:0]          free_chain;
  logic [SLOT_COUNT-1:0]        win_hit;
  logic [SLOT_COUNT-1:0]        win_free;
  logic [SLOT_COUNT-1:0]        psel;
  logic [REF_BITS-1:0]          cell_count [SLOT_COUNT];
  logic [INODE_BITS-1:0]        cell_inode [SLOT_COUNT];

  logic                         any_hit;
  logic                         any_free;
  logic                         any_psel;
  logic [IDX_W-1:0]             hit_idx;
  logic [IDX_W-1:0]             free_idx;
  logic [REF_BITS-1:0]          hit_count;
  logic [REF_BITS-1:0]          put_count;
  logic [INODE_BITS-1:0]        put_inode;

  irt_pkg::status_t             status_next;
  logic [irt_pkg::SLOT_W-1:0]   slot_next;
  logic [REF_BITS-1:0]          refs_next;
  logic [INODE_BITS-1:0]        inode_next;
  logic                         sat_next;

  assign cap  = start && !busy;
  assign busy = (state == EXEC);

  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;
  assign any_hit  = hit_chain[SLOT_COUNT];
  assign any_free = free_chain[SLOT_COUNT];
  assign any_psel = |psel;

  always_comb begin
    cmd          = '0;
    cmd.go       = (state == EXEC);
    cmd.is_get   = (req == irt_pkg::REQ_GET);
    cmd.is_put   = (req == irt_pkg::REQ_PUT);
    cmd.is_clear = (req == irt_pkg::REQ_CLEAR);
    cmd.any_hit  = any_hit;
  end

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    irt_cell #(
      .INODE_BITS (INODE_BITS),
      .REF_BITS   (REF_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cap       (cap),
      .cap_inode (INODE_BITS'(inode_number)),
      .cap_slot  (slot_index),
      .cmd       (cmd),
      .new_inode (req_inode),
      .hit_in    (hit_chain[i]),
      .free_in   (free_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .free_out  (free_chain[i+1]),
      .win_hit   (win_hit[i]),
      .win_free  (win_free[i]),
      .psel      (psel[i]),
      .count     (cell_count[i]),
      .inode     (cell_inode[i])
    );
  end

  // Winners are one-hot, so an OR of the gated values selects them
  always_comb begin
    hit_idx   = '0;
    free_idx  = '0;
    hit_count = '0;
    put_count = '0;
    put_inode = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (win_hit[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_count = hit_count | cell_count[i];
      end
      if (win_free[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
      if (psel[i]) begin
        put_count = put_count | cell_count[i];
        put_inode = put_inode | cell_inode[i];
      end
    end
  end

  always_comb begin
    status_next = irt_pkg::ST_CLEARED;
    slot_next   = '0;
    refs_next   = '0;
    inode_next  = '0;
    sat_next    = 1'b0;
    unique case (req)
      irt_pkg::REQ_GET: begin
        inode_next = req_inode;
        if (any_hit) begin
          status_next = irt_pkg::ST_HIT;
          slot_next   = irt_pkg::SLOT_W'(hit_idx);
          sat_next    = (hit_count == REF_MAX);
          refs_next   = sat_next ? hit_count : hit_count + 1'b1;
        end else if (any_free) begin
          status_next = irt_pkg::ST_LOADED_NEW;
          slot_next   = irt_pkg::SLOT_W'(free_idx);
          refs_next   = REF_BITS'(1);
        end else begin
          status_next = irt_pkg::ST_FULL;
        end
      end
      irt_pkg::REQ_PUT: begin
        slot_next = req_slot;
        if (!any_psel || put_count == '0) begin
          status_next = irt_pkg::ST_IDLE_PUT;
        end else begin
          refs_next   = put_count - 1'b1;
          inode_next  = put_inode;
          status_next = (refs_next == '0) ? irt_pkg::ST_RELEASED_LAST
                                          : irt_pkg::ST_RELEASED;
        end
      end
      irt_pkg::REQ_CLEAR: begin
        status_next = irt_pkg::ST_CLEARED;
      end
      default: begin
        status_next = irt_pkg::ST_CLEARED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state <= IDLE;
          done  <= (req != irt_pkg::REQ_NONE);
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers
  always_ff @(posedge clk) begin
    if (cap) begin
      req       <= irt_pkg::req_t'(req_type);
      req_inode <= INODE_BITS'(inode_number);
      req_slot  <= slot_index;
    end
    if (state == EXEC) begin
      status          <= status_next;
      slot_out        <= slot_next;
      refs_after      <= irt_pkg::REFS_W'(refs_next);
      inode_out       <= irt_pkg::INODE_W'(inode_next);
      count_saturated <= sat_next;
    end
  end

  a_one_hit: assert property (@(posedge clk) disable iff (rst) $onehot0(win_hit))
    else $error("more than one slot won the hit chain");

  a_one_free: assert property (@(posedge clk) disable iff (rst) $onehot0(win_free))
    else $error("more than one slot won the free chain");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    (state == EXEC) |=> (state == IDLE))
    else $error("execute cycle did not end after one cycle");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == EXEC) && !busy)
    else $error("result strobe without a preceding execute cycle");

  a_accept: assert property (@(posedge clk) disable iff (rst) cap |=> busy)
    else $error("accepted item did not enter execute");

endmodule

`default_nettype wire

// ===== sim/irt_table_checker.sv =====
module irt_table_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [irt_pkg::REQ_W-1:0]     req_type,
  input  logic [irt_pkg::INODE_W-1:0]   inode_number,
  input  logic [irt_pkg::SLOT_W-1:0]    slot_index,
  input  logic                          done,
  input  logic [irt_pkg::STATUS_W-1:0]  status,
  input  logic [irt_pkg::SLOT_W-1:0]    slot_out,
  input  logic [irt_pkg::REFS_W-1:0]    refs_after,
  input  logic [irt_pkg::INODE_W-1:0]   inode_out,
  input  logic                          count_saturated,
  output int                            fail_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import irt_pkg::*;

  localparam int SLOTS   = SLOT_COUNT_DEF;
  localparam int REF_MAX = (1 << REF_BITS_DEF) - 1;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [REFS_W-1:0]    refs;
    logic [INODE_W-1:0]   inode;
    logic                 saturated;
  } table_reply_t;

  logic [REFS_W-1:0]  slot_refs   [SLOTS];
  logic [INODE_W-1:0] slot_inodes [SLOTS];
  table_reply_t       replies_due [$];
  int                 mismatches = 0;

  assign fail_count = mismatches;

  // Apply one request to the shadow table; returns 0 when no result follows.
  function automatic bit serve_request(input req_t req, input logic [INODE_W-1:0] ino,
                                       input logic [SLOT_W-1:0] slot,
                                       output table_reply_t reply);
    bit at_max;
    reply.status    = ST_CLEARED;
    reply.slot      = '0;
    reply.refs      = '0;
    reply.inode     = '0;
    reply.saturated = 1'b0;
    case (req)
      REQ_GET: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_refs[i] != 0 && slot_inodes[i] == ino) begin
            at_max = (slot_refs[i] == REF_MAX);
            if (!at_max) slot_refs[i] = slot_refs[i] + 1'b1;
            reply.status    = ST_HIT;
            reply.slot      = SLOT_W'(i);
            reply.refs      = slot_refs[i];
            reply.inode     = ino;
            reply.saturated = at_max;
            return 1'b1;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_refs[i] == 0) begin
            slot_refs[i]   = 1;
            slot_inodes[i] = ino;
            reply.status   = ST_LOADED_NEW;
            reply.slot     = SLOT_W'(i);
            reply.refs     = 1;
            reply.inode    = ino;
            return 1'b1;
          end
        end
        reply.status = ST_FULL;
        reply.inode  = ino;
      end
      REQ_PUT: begin
        reply.slot = slot;
        if (slot_refs[slot] == 0) begin
          reply.status = ST_IDLE_PUT;
        end else begin
          slot_refs[slot] = slot_refs[slot] - 1'b1;
          reply.status = (slot_refs[slot] == 0) ? ST_RELEASED_LAST : ST_RELEASED;
          reply.refs   = slot_refs[slot];
          reply.inode  = slot_inodes[slot];
        end
      end
      REQ_CLEAR: begin
        foreach (slot_refs[i]) slot_refs[i] = '0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t fresh;
    if (rst) begin
      foreach (slot_refs[i]) begin
        slot_refs[i]   = '0;
        slot_inodes[i] = '0;
      end
      replies_due.delete();
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with no item waiting, status %0d slot %0d", $time,
                   status, slot_out);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, status);
          check_field("slot_out", want.slot, slot_out);
          check_field("refs_after", want.refs, refs_after);
          check_field("inode_out", want.inode, inode_out);
          check_field("count_saturated", want.saturated, count_saturated);
        end
      end
      if (start && !busy) begin
        if (serve_request(req_t'(req_type), inode_number, slot_index, fresh))
          replies_due.push_back(fresh);
      end
    end
    outstanding <= replies_due.size();
  end

endmodule

// ===== sim/tb_inode_refcount_table_unit.sv =====
module tb_inode_refcount_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import irt_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int POOL_SIZE   = 24;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [REQ_W-1:0]     req_type = REQ_NONE;
  logic [INODE_W-1:0]   inode_number = '0;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic                 busy;
  logic                 done;
  logic [STATUS_W-1:0]  status;
  logic [SLOT_W-1:0]    slot_out;
  logic [REFS_W-1:0]    refs_after;
  logic [INODE_W-1:0]   inode_out;
  logic                 count_saturated;
  int                   fail_count;
  int                   outstanding;
  int                   stall_cycles = 0;
  bit                   gaps_on = 1'b1;
  logic [INODE_W-1:0]   hot_inodes [POOL_SIZE];

  inode_refcount_table_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .req_type        (req_type),
    .inode_number    (inode_number),
    .slot_index      (slot_index),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .slot_out        (slot_out),
    .refs_after      (refs_after),
    .inode_out       (inode_out),
    .count_saturated (count_saturated)
  );

  irt_table_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .inode_number    (inode_number),
    .slot_index      (slot_index),
    .done            (done),
    .status          (status),
    .slot_out        (slot_out),
    .refs_after      (refs_after),
    .inode_out       (inode_out),
    .count_saturated (count_saturated),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // End the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Present one item and hold it until the edge that accepts it.
  task automatic issue_request(input req_t req, input logic [INODE_W-1:0] ino,
                               input logic [SLOT_W-1:0] slot);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start        <= 1'b1;
    req_type     <= req;
    inode_number <= ino;
    slot_index   <= slot;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue_random(input int get_pct, input bit pooled);
    int pick;
    logic [INODE_W-1:0] ino;
    logic [SLOT_W-1:0] slot;
    pick = $urandom_range(0, 99);
    ino  = (pooled && $urandom_range(0, 4) != 0) ?
           hot_inodes[$urandom_range(0, POOL_SIZE - 1)] : INODE_W'($urandom);
    slot = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 31)) : SLOT_W'($urandom);
    if (pick < get_pct)
      issue_request(REQ_GET, ino, slot);
    else if (pick < 95)
      issue_request(REQ_PUT, ino, slot);
    else if (pick < 97)
      issue_request(REQ_CLEAR, ino, slot);
    else
      issue_request(REQ_NONE, ino, slot);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [INODE_W-1:0] hot;
    foreach (hot_inodes[i]) hot_inodes[i] = INODE_W'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: idle puts, load, hit, release, reuse of lowest free slot, clear
    issue_request(REQ_PUT,   16'h0000, 6'd0);
    issue_request(REQ_PUT,   16'hFFFF, 6'd63);
    issue_request(REQ_GET,   16'h0000, 6'd0);
    issue_request(REQ_GET,   16'hFFFF, 6'd63);
    issue_request(REQ_GET,   16'h0000, 6'd0);
    issue_request(REQ_GET,   16'hFFFF, 6'd0);
    issue_request(REQ_NONE,  16'h1234, 6'd21);
    issue_request(REQ_PUT,   16'h0000, 6'd0);
    issue_request(REQ_PUT,   16'h0000, 6'd0);
    issue_request(REQ_PUT,   16'h0000, 6'd0);
    issue_request(REQ_GET,   16'h8001, 6'd0);
    issue_request(REQ_GET,   16'h00FF, 6'd0);
    issue_request(REQ_PUT,   16'h0000, 6'd1);
    issue_request(REQ_GET,   16'h8001, 6'd0);
    issue_request(REQ_CLEAR, 16'hFFFF, 6'd63);
    issue_request(REQ_PUT,   16'h0000, 6'd2);
    issue_request(REQ_GET,   16'h00FF, 6'd0);
    issue_request(REQ_PUT,   16'h0000, 6'd63);
    issue_request(REQ_PUT,   16'h0000, 6'd0);
    issue_request(REQ_NONE,  16'hFFFF, 6'd63);

    // mixed traffic over a small inode pool so hits and releases are common
    repeat (300) issue_random(55, 1'b1);

    // hold off until the table has answered everything
    drain_results();

    // drive one inode past the count limit
    hot = INODE_W'($urandom);
    issue_request(REQ_CLEAR, hot, 6'd0);
    repeat (258) issue_request(REQ_GET, hot, SLOT_W'($urandom));
    issue_request(REQ_PUT, hot, 6'd0);
    issue_request(REQ_GET, hot, 6'd0);
    issue_request(REQ_GET, hot, 6'd0);

    // fill the table with fresh inodes until it reports full
    issue_request(REQ_CLEAR, hot, 6'd0);
    repeat (70) issue_request(REQ_GET, INODE_W'($urandom), SLOT_W'($urandom));
    repeat (130) issue_random(50, 1'b0);

    gaps_on = 1'b0;
    repeat (60) issue_random(50, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
